@@ rtl/matrix4_multiply_assert.svh @@
// Assertion macros for the matrix multiplier.
`ifndef MATRIX4_MULTIPLY_ASSERT_SVH
`define MATRIX4_MULTIPLY_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked on a given clock, disabled while the given active-low reset is low
`define M4_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on the block clock and reset
`define M4_ASSERT(lbl, prop, msg) \
  `M4_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define M4_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define M4_ASSERT(lbl, prop, msg)
`endif

`endif

@@ rtl/m4mul_pkg.sv @@
package m4mul_pkg;

  // Element width and default configuration
  localparam int DATA_W        = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_DIM       = 4;

  // Beat kinds on the input stream
  typedef enum logic [1:0] {
    OP_LOAD_L   = 2'd0,
    OP_LOAD_R   = 2'd1,
    OP_MUL      = 2'd2,
    OP_MUL_INTO = 2'd3
  } opcode_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

endpackage

@@ rtl/matrix4_multiply.sv @@
// Fixed-point DIM x DIM matrix multiplier (4x4 by default), column-major, signed Q16.16.
// Left and right matrices both come out of reset as identity. A load beat (tuser 0 or 1)
// writes one element; an index past the last element is dropped. A multiply beat (tuser
// 2) streams the DIM*DIM product elements in column-major order with tlast on the final
// one; tuser 3 does the same and the product then replaces the left matrix. Each element
// is an exact sum of DIM products, shifted right arithmetically by FRAC_BITS and
// saturated to 32 bits. All products run through one 32x32 multiplier and one accumulator,
// one product per cycle while an element's operands are read: each element passes its DIM
// operand reads, the multiplier and accumulator stages and an emit, which waits until the
// result register is free, before the next element begins. The input is not ready while a
// multiply is in progress; the result register lets the next beat in as soon as the last
// element has been handed to it.
`include "matrix4_multiply_assert.svh"

module matrix4_multiply #(
  parameter int FRAC_BITS = m4mul_pkg::DEF_FRAC_BITS,
  parameter int DIM       = m4mul_pkg::DEF_DIM
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] elem_index, [35:4] elem_value, [39:36] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] out_index, [35:4] out_value, [39:36] zero
  output logic        m_axis_tlast    // out_last
);
  import m4mul_pkg::*;

  localparam int NELEM = DIM * DIM;
  localparam int IDX_W = $clog2(NELEM);
  localparam int CNT_W = $clog2(DIM);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W = PROD_W + $clog2(DIM);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

  // Input beat fields
  opcode_e           in_op;
  logic [3:0]        in_idx;
  logic [DATA_W-1:0] in_val;
  logic              in_beat;
  logic              in_idx_ok;

  assign in_op     = opcode_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[3:0];
  assign in_val    = s_axis_tdata[35:4];
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign in_idx_ok = int'(in_idx) < NELEM;

  // Matrix storage: two left banks (active and product target) and the right matrix
  logic [DATA_W-1:0] l_mem_q [2][NELEM];
  logic [DATA_W-1:0] r_mem_q [NELEM];
  logic              bank_q;

  // Sequencer state and counters
  state_e            state_q, state_d;
  logic              into_q;
  logic [CNT_W-1:0]  k_q, row_q, col_q;
  logic [IDX_W-1:0]  e_q;
  logic              last_k, last_row, last_e;

  // Pipeline: operands, product, accumulator
  logic signed [DATA_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     p1_vld_q, p1_first_q, p1_end_q;
  logic                     p2_vld_q, p2_first_q, p2_end_q;
  logic                     done_q;

  // Result register
  logic              out_vld_q;
  logic [3:0]        out_idx_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_last_q;

  // Sequencer controls
  logic start, issue, emit, out_free;

  logic [IDX_W-1:0]         l_addr, r_addr;
  logic signed [ACC_W-1:0]  shr;
  logic [DATA_W-1:0]        sat_val;

  assign last_k   = k_q == CNT_W'(DIM - 1);
  assign last_row = row_q == CNT_W'(DIM - 1);
  assign last_e   = e_q == IDX_W'(NELEM - 1);
  assign out_free = !out_vld_q || m_axis_tready;

  assign l_addr = IDX_W'(int'(k_q) * DIM + int'(row_q));
  assign r_addr = IDX_W'(int'(col_q) * DIM + int'(k_q));

  // Shift and saturate the finished sum
  assign shr = acc_q >>> FRAC_BITS;
  always_comb begin
    if (shr > SAT_HI) begin
      sat_val = SAT_HI[DATA_W-1:0];
    end else if (shr < SAT_LO) begin
      sat_val = SAT_LO[DATA_W-1:0];
    end else begin
      sat_val = shr[DATA_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && (in_op == OP_MUL || in_op == OP_MUL_INTO)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (done_q && out_free) begin
          state_d = last_e ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    start         = 1'b0;
    issue         = 1'b0;
    emit          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        start = in_beat && (in_op == OP_MUL || in_op == OP_MUL_INTO);
      end
      ST_ISSUE: issue = 1'b1;
      ST_WAIT:  emit  = done_q && out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      into_q     <= 1'b0;
      bank_q     <= 1'b0;
      k_q        <= '0;
      row_q      <= '0;
      col_q      <= '0;
      e_q        <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      done_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
      if (start) begin
        into_q <= in_op == OP_MUL_INTO;
        k_q    <= '0;
        row_q  <= '0;
        col_q  <= '0;
        e_q    <= '0;
      end
      if (issue) begin
        k_q <= last_k ? '0 : k_q + 1'b1;
      end
      // done flag: set when the final product of an element lands, cleared on emit
      if (emit) begin
        done_q <= 1'b0;
      end else if (p2_vld_q && p2_end_q) begin
        done_q <= 1'b1;
      end
      if (emit) begin
        e_q   <= e_q + 1'b1;
        row_q <= last_row ? '0 : row_q + 1'b1;
        if (last_row) begin
          col_q <= col_q + 1'b1;
        end
        if (last_e && into_q) begin
          bank_q <= !bank_q;
        end
      end
      // result register handshake
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Matrix storage, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NELEM; i++) begin
        l_mem_q[0][i] <= (i % (DIM + 1) == 0) ? ONE : '0;
        l_mem_q[1][i] <= (i % (DIM + 1) == 0) ? ONE : '0;
        r_mem_q[i]    <= (i % (DIM + 1) == 0) ? ONE : '0;
      end
    end else begin
      if (in_beat && in_idx_ok) begin
        unique case (in_op)
          OP_LOAD_L: l_mem_q[bank_q][IDX_W'(in_idx)] <= in_val;
          OP_LOAD_R: r_mem_q[IDX_W'(in_idx)] <= in_val;
          default: ;
        endcase
      end
      // product elements of a multiply-into-left go to the idle bank
      if (emit && into_q) begin
        l_mem_q[!bank_q][e_q] <= sat_val;
      end
    end
  end

  // Datapath: operand fetch, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_q        <= l_mem_q[bank_q][l_addr];
      b_q        <= r_mem_q[r_addr];
      p1_first_q <= k_q == '0;
      p1_end_q   <= last_k;
    end
    prod_q     <= a_q * b_q;
    p2_first_q <= p1_first_q;
    p2_end_q   <= p1_end_q;
    if (p2_vld_q) begin
      acc_q <= (p2_first_q ? '0 : acc_q) + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (emit) begin
      out_idx_q  <= 4'(e_q);
      out_val_q  <= sat_val;
      out_last_q <= last_e;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  // Checks
  `M4_ASSERT(a_idle_empty, state_q == ST_IDLE |-> !done_q && !p1_vld_q && !p2_vld_q,
             "pipeline busy while sequencer idle")
  `M4_ASSERT(a_last_pos, m_axis_tvalid && m_axis_tlast |-> out_idx_q == 4'(NELEM - 1),
             "tlast on an element other than the final one")
  `M4_ASSERT(a_bank_flip, !$stable(bank_q) |-> $past(into_q) && $past(emit),
             "left bank switched outside a multiply-into-left")
  `M4_ASSERT(a_emit_wait, emit |-> state_q == ST_WAIT && !p1_vld_q && !p2_vld_q,
             "element emitted before its products were summed")

endmodule
